>>> rtl/core/lrp_pkg.sv
`timescale 1ns / 1ps
package lrp_pkg;

  // field widths
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 6;
  localparam int VAL_W      = 16;
  localparam int ACC_W      = 32;
  localparam int SUM_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int BETA_W     = 12;
  localparam int CNT_W      = 7;

  // datapath widths
  localparam int BT_W    = VAL_W + 8;          // bias * 256
  localparam int Z_W     = ACC_W + 1;          // product plus bias share
  localparam int SHARE_W = BT_W + 1;
  localparam int M_W     = Z_W + VAL_W;        // z * r
  localparam int DVD_W   = M_W - 1 + 8;        // |z * r| * 256
  localparam int DVS_W   = ACC_W;
  localparam int COEF_W  = BETA_W + 1;         // alpha = 256 + beta
  localparam int T_W     = ACC_W + COEF_W + 1;
  localparam int T8_W    = T_W - 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WEIGHT = 3'd0,
    CMD_BIAS   = 3'd1,
    CMD_ACT    = 3'd2,
    CMD_UREL   = 3'd3,
    CMD_RUN    = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA      = 3'd0,
    CFG_BIAS_EN   = 3'd1,
    CFG_BIAS_MODE = 3'd2,
    CFG_NUM_IN    = 3'd3,
    CFG_NUM_OUT   = 3'd4
  } cfg_idx_e;

  // saturate a wide signed sum to the q16.16 range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
    logic hi_one;
    logic hi_zero;
    hi_one  = &v[SUM_W-1:ACC_W-1];
    hi_zero = ~|v[SUM_W-1:ACC_W-1];
    if (hi_one || hi_zero) begin
      return v[ACC_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/core/lrp_if.sv
`timescale 1ns / 1ps
interface lrp_in_if;
  import lrp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] out_index;
  logic [IDX_W-1:0] in_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, command, out_index, in_index, value, input ready);
  modport sink (input valid, command, out_index, in_index, value, output ready);
endinterface

interface lrp_out_if;
  import lrp_pkg::*;
  logic             valid;
  logic             ready;
  logic signed [ACC_W-1:0] relevance;
  logic [IDX_W-1:0] in_index_res;
  logic             run_done;

  modport source (output valid, relevance, in_index_res, run_done, input ready);
  modport sink (input valid, relevance, in_index_res, run_done, output ready);
endinterface

>>> rtl/core/lrp_alpha_beta_dense_layer_core.sv
`timescale 1ns / 1ps
// load items (weight, bias, activation, upper relevance) are written straight into their memories
// read item: the relevance is read into a register, then presented from the output registers;
// run: a sum pass (with a bias division per output in spread bias mode) then a share
// pass, with a division per nonzero share, both done on the shared serial divider
// reset is asynchronous: control and config go to defaults, memories keep garbage
module lrp_alpha_beta_dense_layer_core #(
  parameter int MAX_IN  = 64,
  parameter int MAX_OUT = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lrp_in_if.sink                          in_i,
  lrp_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [lrp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lrp_pkg::*;

  localparam int IAW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int OAW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WDEPTH = MAX_IN * MAX_OUT;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

  // one-hot sequencer states
  typedef enum logic [25:0] {
    S_IDLE    = 26'b1 << 0,
    S_RD_WAIT = 26'b1 << 1,
    S_ROW1    = 26'b1 << 2,
    S_BIAS    = 26'b1 << 3,
    S_BDIV    = 26'b1 << 4,
    S_P1_RD   = 26'b1 << 5,
    S_P1_MUL  = 26'b1 << 6,
    S_P1_ADD  = 26'b1 << 7,
    S_P1_ACC  = 26'b1 << 8,
    S_P1_END  = 26'b1 << 9,
    S_P1_WR   = 26'b1 << 10,
    S_ROW2    = 26'b1 << 11,
    S_ROW2_LD = 26'b1 << 12,
    S_P2_RD   = 26'b1 << 13,
    S_P2_MUL  = 26'b1 << 14,
    S_P2_ADD  = 26'b1 << 15,
    S_P2_CHK  = 26'b1 << 16,
    S_P2_MR   = 26'b1 << 17,
    S_P2_DIV  = 26'b1 << 18,
    S_P2_SAT  = 26'b1 << 19,
    S_P2_SCL  = 26'b1 << 20,
    S_P2_UPD  = 26'b1 << 21,
    S_P2_WR   = 26'b1 << 22,
    S_P2_NEXT = 26'b1 << 23,
    S_DONE    = 26'b1 << 24,
    S_SPARE   = 26'b1 << 25
  } state_e;

  // ---------------------------------------------------------------- config
  logic [BETA_W-1:0] beta_q;
  logic              bias_en_q;
  logic              bias_mode_q;
  logic [CNT_W-1:0]  num_in_q;
  logic [CNT_W-1:0]  num_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q      <= '0;
      bias_en_q   <= 1'b1;
      bias_mode_q <= 1'b0;
      num_in_q    <= CNT_W'(64);
      num_out_q   <= CNT_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BETA:      beta_q      <= cfg_data_i[BETA_W-1:0];
        CFG_BIAS_EN:   bias_en_q   <= cfg_data_i[0];
        CFG_BIAS_MODE: bias_mode_q <= cfg_data_i[0];
        CFG_NUM_IN:    num_in_q    <= cfg_data_i[CNT_W-1:0];
        CFG_NUM_OUT:   num_out_q   <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         i_q, i_d, j_q, j_d, k_q, k_d, n_q, n_d;
  logic [WAW-1:0]           w_row_q, w_row_d;
  logic                     out_valid_q, out_valid_d;
  logic [MAX_IN-1:0]        irel_vld_q, irel_vld_d;

  logic signed [ACC_W-1:0]   ps_q, ps_d, ns_q, ns_d;
  logic signed [SHARE_W-1:0] share_q, share_d;
  logic signed [VAL_W-1:0]   r_q, r_d;
  logic signed [ACC_W-1:0]   prod_q, prod_d;
  logic signed [Z_W-1:0]     z_q, z_d;
  logic signed [M_W-1:0]     m_q, m_d;
  logic                      sel_neg_q, sel_neg_d;
  logic                      q_neg_q, q_neg_d;
  logic signed [ACC_W-1:0]   q_q, q_d;
  logic signed [T_W-1:0]     t_q, t_d;
  logic signed [T8_W-1:0]    t8_q, t8_d;
  logic                      rd_ok_q, rd_ok_d;
  logic [IDX_W-1:0]          rd_idx_q, rd_idx_d;
  logic signed [ACC_W-1:0]   out_rel_q, out_rel_d;
  logic [IDX_W-1:0]          out_idx_q, out_idx_d;
  logic                      out_done_q, out_done_d;

  // ---------------------------------------------------------------- handshake
  logic  in_acc;
  cmd_e  cmd;
  logic  oi_ok, ii_ok;
  logic [CNT_W-1:0] k_eff, n_eff;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.command);
  assign oi_ok      = 32'(in_i.out_index) < MAX_OUT;
  assign ii_ok      = 32'(in_i.in_index) < MAX_IN;
  assign k_eff      = (32'(num_in_q) > MAX_IN) ? CNT_W'(MAX_IN) : num_in_q;
  assign n_eff      = (32'(num_out_q) > MAX_OUT) ? CNT_W'(MAX_OUT) : num_out_q;

  assign out_o.valid        = out_valid_q;
  assign out_o.relevance    = out_rel_q;
  assign out_o.in_index_res = out_idx_q;
  assign out_o.run_done     = out_done_q;

  // ---------------------------------------------------------------- memories
  logic [IAW-1:0] i_addr;
  logic [OAW-1:0] j_addr;
  logic [WAW-1:0] w_ra;

  assign i_addr = IAW'(i_q);
  assign j_addr = OAW'(j_q);
  assign w_ra   = w_row_q + WAW'(i_q);

  // weights, row j at j*MAX_IN
  logic signed [VAL_W-1:0] w_mem [WDEPTH];
  logic signed [VAL_W-1:0] w_rd_q;
  logic                    w_we, pr_re;
  logic [WAW-1:0]          w_wa;

  assign w_we = in_acc && (cmd == CMD_WEIGHT) && oi_ok && ii_ok;
  assign w_wa = WAW'(32'(in_i.out_index) * MAX_IN + 32'(in_i.in_index));

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_wa] <= in_i.value;
    if (pr_re) w_rd_q <= w_mem[w_ra];
  end

  // activations
  logic signed [VAL_W-1:0] a_mem [MAX_IN];
  logic signed [VAL_W-1:0] a_rd_q;
  logic                    a_we;

  assign a_we = in_acc && (cmd == CMD_ACT) && ii_ok;

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[IAW'(in_i.in_index)] <= in_i.value;
    if (pr_re) a_rd_q <= a_mem[i_addr];
  end

  // biases
  logic signed [VAL_W-1:0] b_mem [MAX_OUT];
  logic signed [VAL_W-1:0] b_rd_q;
  logic                    b_we, b_re;

  assign b_we = in_acc && (cmd == CMD_BIAS) && oi_ok;

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[OAW'(in_i.out_index)] <= in_i.value;
    if (b_re) b_rd_q <= b_mem[j_addr];
  end

  // upper relevances
  logic signed [VAL_W-1:0] u_mem [MAX_OUT];
  logic signed [VAL_W-1:0] u_rd_q;
  logic                    u_we, row_re;

  assign u_we = in_acc && (cmd == CMD_UREL) && oi_ok;

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[OAW'(in_i.out_index)] <= in_i.value;
    if (row_re) u_rd_q <= u_mem[j_addr];
  end

  // per-output sums and bias share, written in the first pass
  logic signed [ACC_W-1:0]   ps_mem [MAX_OUT];
  logic signed [ACC_W-1:0]   ns_mem [MAX_OUT];
  logic signed [SHARE_W-1:0] sh_mem [MAX_OUT];
  logic signed [ACC_W-1:0]   ps_rd_q, ns_rd_q;
  logic signed [SHARE_W-1:0] sh_rd_q;
  logic                      s_we;

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      ps_mem[j_addr] <= ps_q;
      ns_mem[j_addr] <= ns_q;
      sh_mem[j_addr] <= share_q;
    end
    if (row_re) begin
      ps_rd_q <= ps_mem[j_addr];
      ns_rd_q <= ns_mem[j_addr];
      sh_rd_q <= sh_mem[j_addr];
    end
  end

  // input relevances, valid bits make unwritten entries read as zero
  logic signed [ACC_W-1:0] r_mem [MAX_IN];
  logic signed [ACC_W-1:0] r_rd_q;
  logic signed [ACC_W-1:0] r_wd;
  logic                    r_we, r_re;
  logic [IAW-1:0]          r_ra;

  always_ff @(posedge clk_i) begin
    if (r_we) r_mem[i_addr] <= r_wd;
    if (r_re) r_rd_q <= r_mem[r_ra];
  end

  // ---------------------------------------------------------------- divider
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quo;
  logic [DVS_W-1:0]   div_dvs;

  lrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  // ---------------------------------------------------------------- datapath terms
  logic signed [BT_W-1:0]  bt;
  logic [BT_W-1:0]         bt_mag;
  logic signed [SUM_W-1:0] bt_ext, z_ext, ps_ext, ns_ext;
  logic signed [SUM_W-1:0] old_ext, t8_ext;
  logic signed [ACC_W-1:0] old_rel;
  logic [M_W-1:0]          m_mag;
  logic                    z_pos, z_neg, bt_pos;
  logic [COEF_W-1:0]       coef;
  logic signed [T_W-1:0]   t_rnd;
  logic                    q_ovf_pos, q_ovf_neg;

  assign bt      = {b_rd_q, 8'h00};
  assign bt_mag  = b_rd_q[VAL_W-1] ? BT_W'(-bt) : BT_W'(bt);
  assign bt_pos  = !b_rd_q[VAL_W-1] && (|b_rd_q);
  assign bt_ext  = {{(SUM_W-BT_W){bt[BT_W-1]}}, bt};
  assign z_ext   = {{(SUM_W-Z_W){z_q[Z_W-1]}}, z_q};
  assign ps_ext  = {{(SUM_W-ACC_W){ps_q[ACC_W-1]}}, ps_q};
  assign ns_ext  = {{(SUM_W-ACC_W){ns_q[ACC_W-1]}}, ns_q};
  assign z_pos   = !z_q[Z_W-1] && (|z_q);
  assign z_neg   = z_q[Z_W-1];
  assign m_mag   = m_q[M_W-1] ? M_W'(-m_q) : M_W'(m_q);
  // alpha for positive shares, beta for negative ones
  assign coef    = sel_neg_q ? COEF_W'(beta_q) : (COEF_W'(beta_q) + COEF_W'(256));
  // divide by 256 truncating toward zero
  assign t_rnd   = t_q + {{(T_W-8){1'b0}}, {8{t_q[T_W-1]}}};
  assign old_rel = irel_vld_q[i_addr] ? r_rd_q : '0;
  assign old_ext = {{(SUM_W-ACC_W){old_rel[ACC_W-1]}}, old_rel};
  assign t8_ext  = {{(SUM_W-T8_W){t8_q[T8_W-1]}}, t8_q};
  assign q_ovf_pos = |div_quo[DVD_W-1:ACC_W-1];
  assign q_ovf_neg = (|div_quo[DVD_W-1:ACC_W]) ||
                     (div_quo[ACC_W-1] && (|div_quo[ACC_W-2:0]));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    n_d         = n_q;
    w_row_d     = w_row_q;
    out_valid_d = out_valid_q;
    irel_vld_d  = irel_vld_q;
    ps_d        = ps_q;
    ns_d        = ns_q;
    share_d     = share_q;
    r_d         = r_q;
    prod_d      = prod_q;
    z_d         = z_q;
    m_d         = m_q;
    sel_neg_d   = sel_neg_q;
    q_neg_d     = q_neg_q;
    q_d         = q_q;
    t_d         = t_q;
    t8_d        = t8_q;
    rd_ok_d     = rd_ok_q;
    rd_idx_d    = rd_idx_q;
    out_rel_d   = out_rel_q;
    out_idx_d   = out_idx_q;
    out_done_d  = out_done_q;
    pr_re       = 1'b0;
    b_re        = 1'b0;
    row_re      = 1'b0;
    s_we        = 1'b0;
    r_we        = 1'b0;
    r_re        = 1'b0;
    r_ra        = i_addr;
    r_wd        = '0;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_RUN: begin
              k_d        = k_eff;
              n_d        = n_eff;
              irel_vld_d = '0;
              i_d        = '0;
              j_d        = '0;
              w_row_d    = '0;
              ps_d       = '0;
              ns_d       = '0;
              if (k_eff == '0 || n_eff == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_ROW1;
              end
            end
            CMD_READ: begin
              r_re     = 1'b1;
              r_ra     = IAW'(in_i.in_index);
              rd_ok_d  = ii_ok && irel_vld_q[IAW'(in_i.in_index)];
              rd_idx_d = in_i.in_index;
              state_d  = S_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: begin
        out_valid_d = 1'b1;
        out_rel_d   = rd_ok_q ? r_rd_q : '0;
        out_idx_d   = rd_idx_q;
        out_done_d  = 1'b0;
        state_d     = S_IDLE;
      end
      // first pass: positive and negative sums per output
      S_ROW1: begin
        b_re    = 1'b1;
        state_d = S_BIAS;
      end
      S_BIAS: begin
        if (bias_en_q && bias_mode_q) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(bt_mag);
          div_dvs   = DVS_W'(k_q);
          q_neg_d   = b_rd_q[VAL_W-1];
          state_d   = S_BDIV;
        end else begin
          share_d = '0;
          state_d = S_P1_RD;
        end
      end
      S_BDIV: begin
        if (div_done) begin
          share_d = q_neg_q ? -$signed(div_quo[SHARE_W-1:0]) : $signed(div_quo[SHARE_W-1:0]);
          state_d = S_P1_RD;
        end
      end
      S_P1_RD: begin
        pr_re   = 1'b1;
        state_d = S_P1_MUL;
      end
      S_P1_MUL: begin
        prod_d  = a_rd_q * w_rd_q;
        state_d = S_P1_ADD;
      end
      S_P1_ADD: begin
        z_d     = {prod_q[ACC_W-1], prod_q} + {{(Z_W-SHARE_W){share_q[SHARE_W-1]}}, share_q};
        state_d = S_P1_ACC;
      end
      S_P1_ACC: begin
        if (z_pos) ps_d = sat_acc(ps_ext + z_ext);
        else       ns_d = sat_acc(ns_ext + z_ext);
        if (i_q == k_q - 1'b1) begin
          state_d = S_P1_END;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_P1_RD;
        end
      end
      S_P1_END: begin
        // bias as a term of its own
        if (bias_en_q && !bias_mode_q) begin
          if (bt_pos) ps_d = sat_acc(ps_ext + bt_ext);
          else        ns_d = sat_acc(ns_ext + bt_ext);
        end
        state_d = S_P1_WR;
      end
      S_P1_WR: begin
        s_we = 1'b1;
        i_d  = '0;
        ps_d = '0;
        ns_d = '0;
        if (j_q == n_q - 1'b1) begin
          j_d     = '0;
          w_row_d = '0;
          state_d = S_ROW2;
        end else begin
          j_d     = j_q + 1'b1;
          w_row_d = w_row_q + WAW'(MAX_IN);
          state_d = S_ROW1;
        end
      end
      // second pass: shares into the input relevances
      S_ROW2: begin
        row_re  = 1'b1;
        state_d = S_ROW2_LD;
      end
      S_ROW2_LD: begin
        r_d     = u_rd_q;
        ps_d    = ps_rd_q;
        ns_d    = ns_rd_q;
        share_d = sh_rd_q;
        state_d = S_P2_RD;
      end
      S_P2_RD: begin
        pr_re   = 1'b1;
        r_re    = 1'b1;
        state_d = S_P2_MUL;
      end
      S_P2_MUL: begin
        prod_d  = a_rd_q * w_rd_q;
        state_d = S_P2_ADD;
      end
      S_P2_ADD: begin
        z_d     = {prod_q[ACC_W-1], prod_q} + {{(Z_W-SHARE_W){share_q[SHARE_W-1]}}, share_q};
        state_d = S_P2_CHK;
      end
      S_P2_CHK: begin
        // zero sums give no share
        if (z_pos && !ps_q[ACC_W-1] && (|ps_q)) begin
          m_d       = z_q * r_q;
          sel_neg_d = 1'b0;
          state_d   = S_P2_MR;
        end else if (z_neg && ns_q[ACC_W-1]) begin
          m_d       = z_q * r_q;
          sel_neg_d = 1'b1;
          state_d   = S_P2_MR;
        end else begin
          state_d = S_P2_NEXT;
        end
      end
      S_P2_MR: begin
        div_start = 1'b1;
        div_dvd   = {m_mag[M_W-2:0], 8'h00};
        div_dvs   = sel_neg_q ? DVS_W'(-ns_q) : DVS_W'(ps_q);
        q_neg_d   = m_q[M_W-1] ^ sel_neg_q;
        state_d   = S_P2_DIV;
      end
      S_P2_DIV: begin
        if (div_done) state_d = S_P2_SAT;
      end
      S_P2_SAT: begin
        if (q_neg_q) begin
          q_d = q_ovf_neg ? {1'b1, {(ACC_W-1){1'b0}}} : -$signed(div_quo[ACC_W-1:0]);
        end else begin
          q_d = q_ovf_pos ? {1'b0, {(ACC_W-1){1'b1}}} : $signed(div_quo[ACC_W-1:0]);
        end
        state_d = S_P2_SCL;
      end
      S_P2_SCL: begin
        t_d     = q_q * $signed({1'b0, coef});
        state_d = S_P2_UPD;
      end
      S_P2_UPD: begin
        t8_d    = t_rnd[T_W-1:8];
        state_d = S_P2_WR;
      end
      S_P2_WR: begin
        r_we               = 1'b1;
        r_wd               = sat_acc(sel_neg_q ? (old_ext - t8_ext) : (old_ext + t8_ext));
        irel_vld_d[i_addr] = 1'b1;
        state_d            = S_P2_NEXT;
      end
      S_P2_NEXT: begin
        if (i_q == k_q - 1'b1) begin
          i_d = '0;
          if (j_q == n_q - 1'b1) begin
            state_d = S_DONE;
          end else begin
            j_d     = j_q + 1'b1;
            w_row_d = w_row_q + WAW'(MAX_IN);
            state_d = S_ROW2;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_P2_RD;
        end
      end
      S_DONE: begin
        out_valid_d = 1'b1;
        out_rel_d   = '0;
        out_idx_d   = '0;
        out_done_d  = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      n_q         <= '0;
      w_row_q     <= '0;
      out_valid_q <= 1'b0;
      irel_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      n_q         <= n_d;
      w_row_q     <= w_row_d;
      out_valid_q <= out_valid_d;
      irel_vld_q  <= irel_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_q       <= ps_d;
    ns_q       <= ns_d;
    share_q    <= share_d;
    r_q        <= r_d;
    prod_q     <= prod_d;
    z_q        <= z_d;
    m_q        <= m_d;
    sel_neg_q  <= sel_neg_d;
    q_neg_q    <= q_neg_d;
    q_q        <= q_d;
    t_q        <= t_d;
    t8_q       <= t8_d;
    rd_ok_q    <= rd_ok_d;
    rd_idx_q   <= rd_idx_d;
    out_rel_q  <= out_rel_d;
    out_idx_q  <= out_idx_d;
    out_done_q <= out_done_d;
  end

endmodule

>>> rtl/core/lrp_div.sv
`timescale 1ns / 1ps
module lrp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lrp_pkg::DVD_W-1:0]   dividend_i,
  input  logic [lrp_pkg::DVS_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [lrp_pkg::DVD_W-1:0]   quot_o
);
  import lrp_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    shift;
  logic [DVS_W+1:0]  diff;
  logic              ge;

  // one quotient bit per cycle, restoring
  assign shift = {rem_q, quo_q[DVD_W-1]};
  assign diff  = {1'b0, shift} - {2'b00, dvs_q};
  assign ge    = ~diff[DVS_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : shift[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> test/lrp_dense_layer_checker.sv
`timescale 1ns / 1ps
module lrp_dense_layer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lrp_in_if                              in_mon,
  lrp_out_if                             out_mon,
  input  logic                           cfg_we_i,
  input  logic [lrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import lrp_pkg::*;

  typedef struct {
    logic signed [ACC_W-1:0] relevance;
    logic [IDX_W-1:0]        index;
    logic                    done;
  } lrp_result_t;

  localparam int NIN  = 64;
  localparam int NOUT = 64;

  logic signed [VAL_W-1:0] weight_mem [NOUT][NIN];
  logic signed [VAL_W-1:0] bias_mem [NOUT];
  logic signed [VAL_W-1:0] act_mem [NIN];
  logic signed [VAL_W-1:0] urel_mem [NOUT];
  longint                  pos_sum [NOUT];
  longint                  neg_sum [NOUT];
  longint                  in_rel [NIN];

  logic [BETA_W-1:0] beta_q;
  logic              bias_en_q;
  logic              bias_mode_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  n_q;

  lrp_result_t relevance_q [$];
  int          fails;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // q16.16 term of input i into output j, spread bias included
  function automatic longint layer_term(int j, int i, int k);
    longint z;
    z = longint'(act_mem[i]) * longint'(weight_mem[j][i]);
    if (bias_en_q && bias_mode_q && k != 0) z += (longint'(bias_mem[j]) * 256) / k;
    return z;
  endfunction

  function automatic void propagate_layer();
    int     k;
    int     n;
    longint a;
    longint b;
    longint ps;
    longint ns;
    longint z;
    longint r;
    longint q1;
    longint q2;
    longint bt;
    k = (k_q > NIN) ? NIN : int'(k_q);
    n = (n_q > NOUT) ? NOUT : int'(n_q);
    a = 256 + longint'(beta_q);
    b = longint'(beta_q);
    for (int x = 0; x < NIN; x++) in_rel[x] = 0;
    for (int x = 0; x < NOUT; x++) begin
      pos_sum[x] = 0;
      neg_sum[x] = 0;
    end
    for (int j = 0; j < n; j++) begin
      ps = 0;
      ns = 0;
      for (int i = 0; i < k; i++) begin
        z = layer_term(j, i, k);
        if (z > 0) ps = clip32(ps + z);
        else ns = clip32(ns + z);
      end
      if (bias_en_q && !bias_mode_q) begin
        bt = longint'(bias_mem[j]) * 256;
        if (bt > 0) ps = clip32(ps + bt);
        else ns = clip32(ns + bt);
      end
      pos_sum[j] = ps;
      neg_sum[j] = ns;
    end
    for (int j = 0; j < n; j++) begin
      r = longint'(urel_mem[j]);
      for (int i = 0; i < k; i++) begin
        z = layer_term(j, i, k);
        q1 = 0;
        q2 = 0;
        if (pos_sum[j] > 0 && z > 0) q1 = clip32((z * r * 256) / pos_sum[j]);
        if (neg_sum[j] < 0 && z < 0) q2 = clip32((z * r * 256) / neg_sum[j]);
        in_rel[i] = clip32(in_rel[i] + (q1 * a) / 256 - (q2 * b) / 256);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lrp_result_t got;
    lrp_result_t want;
    if (!rst_ni) begin
      beta_q      <= '0;
      bias_en_q   <= 1'b1;
      bias_mode_q <= 1'b0;
      k_q         <= 7'd64;
      n_q         <= 7'd64;
      for (int x = 0; x < NIN; x++) in_rel[x] = 0;
      relevance_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BETA:      beta_q      <= cfg_data_i[BETA_W-1:0];
          CFG_BIAS_EN:   bias_en_q   <= cfg_data_i[0];
          CFG_BIAS_MODE: bias_mode_q <= cfg_data_i[0];
          CFG_NUM_IN:    k_q         <= cfg_data_i[CNT_W-1:0];
          CFG_NUM_OUT:   n_q         <= cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.relevance = out_mon.relevance;
        got.index     = out_mon.in_index_res;
        got.done      = out_mon.run_done;
        if (relevance_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result rel=%0d idx=%0d done=%0b",
                                    got.relevance, got.index, got.done));
        end else begin
          want = relevance_q.pop_front();
          if (got.relevance !== want.relevance)
            report_mismatch($sformatf("relevance %0d, want %0d (idx %0d)",
                                      got.relevance, want.relevance, want.index));
          if (got.index !== want.index)
            report_mismatch($sformatf("in_index_res %0d, want %0d", got.index, want.index));
          if (got.done !== want.done)
            report_mismatch($sformatf("run_done %0b, want %0b", got.done, want.done));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.command)
          CMD_WEIGHT: weight_mem[in_mon.out_index][in_mon.in_index] = in_mon.value;
          CMD_BIAS:   bias_mem[in_mon.out_index] = in_mon.value;
          CMD_ACT:    act_mem[in_mon.in_index] = in_mon.value;
          CMD_UREL:   urel_mem[in_mon.out_index] = in_mon.value;
          CMD_RUN: begin
            propagate_layer();
            want.relevance = '0;
            want.index     = '0;
            want.done      = 1'b1;
            relevance_q.push_back(want);
          end
          CMD_READ: begin
            want.relevance = in_rel[in_mon.in_index][ACC_W-1:0];
            want.index     = in_mon.in_index;
            want.done      = 1'b0;
            relevance_q.push_back(want);
          end
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= relevance_q.size();
    end
  end

endmodule

>>> test/tb_lrp_alpha_beta_dense_layer_core.sv
`timescale 1ns / 1ps
module tb_lrp_alpha_beta_dense_layer_core;
  import lrp_pkg::*;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        oi;
    logic [IDX_W-1:0]        ii;
    logic signed [VAL_W-1:0] val;
  } layer_item_t;

  // 3'd6 and 3'd7 have no meaning to the block and must be dropped
  localparam logic [CMD_W-1:0] CMD_BOGUS_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BOGUS_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  lrp_in_if  in_bus ();
  lrp_out_if out_bus ();

  layer_item_t item_q [$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        rx_hold;
  logic        took;
  int          item_count;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  lrp_alpha_beta_dense_layer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  lrp_dense_layer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // known values on every input from time zero
  initial begin
    in_bus.valid     = 1'b0;
    in_bus.command   = '0;
    in_bus.out_index = '0;
    in_bus.in_index  = '0;
    in_bus.value     = '0;
    out_bus.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    rx_hold          = 1'b0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    item_count       = 0;
  end

  // remember whether the offered item went in at the last rising edge
  always @(posedge clk_i) begin
    took <= in_bus.valid && in_bus.ready;
  end

  // sender: a new item or a gap only once the current one is taken
  always @(negedge clk_i) begin
    layer_item_t it;
    if (rst_ni && (!in_bus.valid || took)) begin
      if (item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = item_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.command   <= it.cmd;
        in_bus.out_index <= it.oi;
        in_bus.in_index  <= it.ii;
        in_bus.value     <= it.val;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a hard hold while rx_hold is up
  always @(negedge clk_i) begin
    if (!rst_ni) out_bus.ready <= 1'b0;
    else if (rx_hold) out_bus.ready <= 1'b0;
    else out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver hold, counted here so the sender keeps pushing reads
  initial begin
    forever begin
      wait (rx_hold);
      repeat (400) @(negedge clk_i);
      rx_hold = 1'b0;
    end
  end

  // generous watchdog
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // q8.8 value with extra weight on the corners
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return VAL_W'($urandom_range(1, 600));
      4: return VAL_W'(-$urandom_range(1, 600));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic push_item(input logic [CMD_W-1:0] cmd, input int oi, input int ii,
                           input int val);
    layer_item_t it;
    it.cmd = cmd;
    it.oi  = IDX_W'(oi);
    it.ii  = IDX_W'(ii);
    it.val = VAL_W'(val);
    item_q.push_back(it);
    if (cmd != CMD_BOGUS_LO && cmd != CMD_BOGUS_HI) item_count++;
  endtask

  // stray items between loads: dropped commands, reads, harmless reloads
  task automatic maybe_noise(input int k, input int n);
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0: push_item(($urandom_range(1) != 0) ? CMD_BOGUS_HI : CMD_BOGUS_LO,
                     $urandom_range(63), $urandom_range(63), $urandom);
        1: push_item(CMD_READ, $urandom_range(63), $urandom_range(63), $urandom);
        2: push_item(CMD_ACT, 0, $urandom_range(k - 1), pick_value());
        default: push_item(CMD_UREL, $urandom_range(n - 1), 0, pick_value());
      endcase
    end
  endtask

  // block is idle: nothing offered, nothing owed, then a short settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (!(item_q.size() == 0 && !in_bus.valid && pending == 0));
    repeat (12) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input int data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_layer(input int beta, input int ben, input int bmode,
                           input int k, input int n);
    wait_idle();
    cfg_write(CFG_BETA, beta);
    cfg_write(CFG_BIAS_EN, ben);
    cfg_write(CFG_BIAS_MODE, bmode);
    cfg_write(CFG_NUM_IN, k);
    cfg_write(CFG_NUM_OUT, n);
  endtask

  // load every entry a run of k by n touches, with random content
  task automatic load_layer(input int k, input int n);
    for (int j = 0; j < n; j++) begin
      for (int i = 0; i < k; i++) begin
        push_item(CMD_WEIGHT, j, i, pick_value());
        maybe_noise(k, n);
      end
      push_item(CMD_BIAS, j, $urandom_range(63), pick_value());
      push_item(CMD_UREL, j, $urandom_range(63), pick_value());
    end
    for (int i = 0; i < k; i++) begin
      push_item(CMD_ACT, $urandom_range(63), i, pick_value());
      maybe_noise(k, n);
    end
  endtask

  // run, then read back the used range and a little past it
  task automatic run_and_read(input int k);
    push_item(CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom);
    for (int i = 0; i < k + 2 && i < 64; i++) push_item(CMD_READ, 0, i, $urandom);
    push_item(CMD_READ, $urandom_range(63), $urandom_range(63), $urandom);
  endtask

  initial begin
    int k;
    int n;
    int kc;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    tx_idle_pct = 26;
    rx_idle_pct = 72;

    // directed: read before any run, dropped commands, corner values
    push_item(CMD_READ, 0, 63, 16'sh7fff);
    push_item(CMD_BOGUS_LO, 63, 63, 16'sh8000);
    push_item(CMD_BOGUS_HI, 0, 0, 16'sh7fff);
    set_layer(0, 1, 0, 2, 2);
    push_item(CMD_WEIGHT, 0, 0, 16'sh7fff);
    push_item(CMD_WEIGHT, 0, 1, 16'sh7fff);
    push_item(CMD_WEIGHT, 1, 0, 16'sh8000);
    push_item(CMD_WEIGHT, 1, 1, 16'sh0100);
    push_item(CMD_ACT, 0, 0, 16'sh7fff);
    push_item(CMD_ACT, 0, 1, 16'sh8000);
    push_item(CMD_BIAS, 0, 0, 16'sh8000);
    push_item(CMD_BIAS, 1, 0, 16'sh7fff);
    push_item(CMD_UREL, 0, 0, 16'sh7fff);
    push_item(CMD_UREL, 1, 0, 16'sh8000);
    run_and_read(2);
    // zero activations leave both sums at zero, so no shares at all
    push_item(CMD_ACT, 0, 0, 16'sh0000);
    push_item(CMD_ACT, 0, 1, 16'sh0000);
    set_layer(4095, 0, 0, 2, 2);
    run_and_read(2);

    // extreme shapes and register values
    set_layer(4095, 1, 1, 64, 1);
    load_layer(64, 1);
    run_and_read(64);
    set_layer(0, 1, 1, 1, 64);
    load_layer(1, 64);
    run_and_read(1);
    // oversized k is limited to the store size, zero sizes cover nothing
    set_layer(128, 1, 0, 127, 1);
    run_and_read(64);
    set_layer(77, 1, 1, 0, 3);
    run_and_read(2);
    set_layer(77, 1, 0, 3, 0);
    run_and_read(3);

    // results stuck behind a long receiver hold while reads keep coming
    set_layer($urandom_range(4095), 1, 0, 2, 2);
    load_layer(2, 2);
    run_and_read(2);
    wait_idle();
    rx_hold = 1'b1;
    for (int r = 0; r < 40; r++) push_item(CMD_READ, 0, $urandom_range(63), $urandom);

    // random sessions, three idling regimes
    while (item_count < 1650) begin
      if (item_count < 600) begin
        tx_idle_pct = 26;
        rx_idle_pct = 72;
      end else if (item_count < 1150) begin
        tx_idle_pct = 72;
        rx_idle_pct = 26;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      k = $urandom_range(1, 5);
      n = $urandom_range(1, 5);
      kc = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 4095 : 0) : $urandom_range(4095);
      set_layer(kc, $urandom_range(1), $urandom_range(1), k, n);
      load_layer(k, n);
      run_and_read(k);
      // sometimes a partial reload and a second run on the same layer
      if ($urandom_range(1) != 0) begin
        push_item(CMD_WEIGHT, $urandom_range(n - 1), $urandom_range(k - 1), pick_value());
        push_item(CMD_ACT, 0, $urandom_range(k - 1), pick_value());
        run_and_read(k);
      end
    end

    wait_idle();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
